// ===== rtl/rectangle_fill_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Rectangle fill engine assertion macros
// Shared property forms for the checker. Each macro expects i_clk and
// i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_FILL_ENGINE_MACROS_SVH
`define RECTANGLE_FILL_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RFE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rectangle fill engine: check failed");

// Next-cycle implication, disabled during reset
`define RFE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rectangle fill engine: check failed");

`endif

// ===== rtl/rfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine package
// Shared constants, register map, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rfe_pkg;

    // Default grid bounds
    localparam int C_MAX_ROWS = 64;
    localparam int C_MAX_COLS = 64;

    // Field widths
    localparam int C_COORD_W = 6;
    localparam int C_DATA_W  = 32;
    localparam int C_SIZE_W  = 7;

    // Configuration port
    localparam int C_CFG_AW = 4;
    localparam int C_CFG_DW = 32;

    // Register indexes
    localparam logic [1:0] REG_GRID_ROWS    = 2'd0;
    localparam logic [1:0] REG_GRID_COLS    = 2'd1;
    localparam logic [1:0] REG_CORNER_ORDER = 2'd2;

    // Register reset values
    localparam logic [C_SIZE_W-1:0] C_GRID_ROWS_RST = 7'd64;
    localparam logic [C_SIZE_W-1:0] C_GRID_COLS_RST = 7'd64;

    // Item and result codes
    localparam logic MODE_FILL     = 1'b0;
    localparam logic MODE_READ     = 1'b1;
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;
    localparam logic ORDER_UL      = 1'b0;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_FILL,
        ST_DONE
    } t_state;

    // Configuration register set
    typedef struct packed {
        logic [C_SIZE_W-1:0] grid_rows;
        logic [C_SIZE_W-1:0] grid_cols;
        logic                corner_order;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic setup;
        logic rd_issue;
        logic fill_step;
        logic post;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic err;
        logic mode;
        logic fill_last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/rfe_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine command channel
// Valid/ready channel carrying one fill or read item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfe_cmd_if;
    import rfe_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [C_COORD_W-1:0]        first_row;
    logic [C_COORD_W-1:0]        first_col;
    logic [C_COORD_W-1:0]        second_row;
    logic [C_COORD_W-1:0]        second_col;
    logic signed [C_DATA_W-1:0]  fill_value;

    modport source (
        output valid, mode, first_row, first_col, second_row, second_col, fill_value,
        input  ready
    );

    modport sink (
        input  valid, mode, first_row, first_col, second_row, second_col, fill_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/rfe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine response channel
// Valid/ready channel carrying one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfe_rsp_if;
    import rfe_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [C_DATA_W-1:0]  read_value;
    logic                        status;

    modport source (
        output valid, read_value, status,
        input  ready
    );

    modport sink (
        input  valid, read_value, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/rfe_ram.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 4096,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/rfe_regs.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine configuration registers
// APB-style register file for grid size and corner order.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rfe_pkg::C_CFG_AW-1:0]   paddr,
    input  wire logic [rfe_pkg::C_CFG_DW-1:0]   pwdata,
    output logic      [rfe_pkg::C_CFG_DW-1:0]   prdata,
    output logic                                pready,
    output rfe_pkg::t_cfg                       o_cfg
);
    import rfe_pkg::*;

    logic [1:0] reg_idx;
    logic       wr_en;
    t_cfg       r_cfg;
    t_cfg       n_cfg;

    assign reg_idx = paddr[C_CFG_AW-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_GRID_ROWS:    n_cfg.grid_rows    = pwdata[C_SIZE_W-1:0];
                REG_GRID_COLS:    n_cfg.grid_cols    = pwdata[C_SIZE_W-1:0];
                REG_CORNER_ORDER: n_cfg.corner_order = pwdata[0];
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_rows    <= C_GRID_ROWS_RST;
            r_cfg.grid_cols    <= C_GRID_COLS_RST;
            r_cfg.corner_order <= ORDER_UL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_GRID_ROWS:    prdata = C_CFG_DW'(r_cfg.grid_rows);
            REG_GRID_COLS:    prdata = C_CFG_DW'(r_cfg.grid_cols);
            REG_CORNER_ORDER: prdata = C_CFG_DW'(r_cfg.corner_order);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/rfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine controller
// Sequences the clearing pass, item intake, cell sweep or cell read and result post.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rfe_pkg::t_dp_sts  i_sts,
    output rfe_pkg::t_dp_cmd       o_cmd
);
    import rfe_pkg::*;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (i_sts.err) begin
                    n_state = ST_DONE;
                end else if (i_sts.mode == MODE_READ) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_FILL: begin
                if (i_sts.fill_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SETUP: o_cmd.setup     = 1'b1;
            ST_READ:  o_cmd.rd_issue  = 1'b1;
            ST_FILL:  o_cmd.fill_step = 1'b1;
            ST_DONE:  o_cmd.post      = !i_sts.out_busy;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rfe_dp.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine datapath
// Corner checks, row/column sweep counters, cell memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_dp #(
    parameter int MAX_ROWS = rfe_pkg::C_MAX_ROWS,
    parameter int MAX_COLS = rfe_pkg::C_MAX_COLS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rfe_pkg::t_cfg                       i_cfg,
    input  wire rfe_pkg::t_dp_cmd                    i_cmd,
    output rfe_pkg::t_dp_sts                         o_sts,
    input  wire logic                                i_mode,
    input  wire logic [rfe_pkg::C_COORD_W-1:0]       i_first_row,
    input  wire logic [rfe_pkg::C_COORD_W-1:0]       i_first_col,
    input  wire logic [rfe_pkg::C_COORD_W-1:0]       i_second_row,
    input  wire logic [rfe_pkg::C_COORD_W-1:0]       i_second_col,
    input  wire logic signed [rfe_pkg::C_DATA_W-1:0] i_fill_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [rfe_pkg::C_DATA_W-1:0]      o_read_value,
    output logic                                     o_status
);
    import rfe_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Item registers
    logic                        r_mode;
    logic                        r_err;
    logic [C_COORD_W-1:0]        r_row;
    logic [C_COORD_W-1:0]        r_row_end;
    logic [C_COORD_W-1:0]        r_col;
    logic [C_COORD_W-1:0]        r_left;
    logic [C_COORD_W-1:0]        r_right;
    logic [C_DATA_W-1:0]         r_value;
    logic [AW-1:0]               r_base;
    logic [AW-1:0]               r_clr;

    // Result register
    logic                        r_out_valid;
    logic signed [C_DATA_W-1:0]  r_out_value;
    logic                        r_out_status;

    logic                        a_in;
    logic                        b_in;
    logic [C_COORD_W-1:0]        left;
    logic [C_COORD_W-1:0]        right;
    logic                        err;
    logic [AW-1:0]               cell_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [C_DATA_W-1:0]         wr_data;
    logic [C_DATA_W-1:0]         rd_data;
    logic                        col_last;

    // Range and corner checks on the incoming item
    always_comb begin
        a_in = ({1'b0, i_first_row} < i_cfg.grid_rows) && (32'(i_first_row) < MAX_ROWS)
            && ({1'b0, i_first_col} < i_cfg.grid_cols) && (32'(i_first_col) < MAX_COLS);
        b_in = ({1'b0, i_second_row} < i_cfg.grid_rows) && (32'(i_second_row) < MAX_ROWS)
            && ({1'b0, i_second_col} < i_cfg.grid_cols) && (32'(i_second_col) < MAX_COLS);
        if (i_cfg.corner_order == ORDER_UL) begin
            left  = i_first_col;
            right = i_second_col;
        end else begin
            left  = i_second_col;
            right = i_first_col;
        end
        if (i_mode == MODE_READ) begin
            err = !a_in;
        end else begin
            err = !a_in || !b_in || (i_first_row > i_second_row) || (left > right);
        end
    end

    // Latch the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_err     <= err;
            r_row     <= i_first_row;
            r_row_end <= i_second_row;
            r_col     <= (i_mode == MODE_READ) ? i_first_col : left;
            r_left    <= left;
            r_right   <= right;
            r_value   <= i_fill_value;
        end else if (i_cmd.fill_step) begin
            // Advance along the row, wrap to the next row at the right edge
            if (col_last) begin
                r_col <= r_left;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Row base address: one multiply at setup, then add a row pitch per row
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_base <= AW'(32'(r_row) * MAX_COLS);
        end else if (i_cmd.fill_step && col_last) begin
            r_base <= AW'(32'(r_base) + MAX_COLS);
        end
    end

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign col_last  = (r_col == r_right);
    assign cell_addr = AW'(32'(r_base) + 32'(r_col));

    // Memory port selection
    assign wr_en   = i_cmd.clr_step || i_cmd.fill_step;
    assign wr_addr = i_cmd.clr_step ? r_clr : cell_addr;
    assign wr_data = i_cmd.clr_step ? '0 : r_value;

    rfe_ram #(
        .WIDTH (C_DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (cell_addr),
        .o_rd_data (rd_data)
    );

    // Result register: load on post, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_status <= r_err ? STATUS_REJECT : STATUS_DONE;
            if (r_mode == MODE_READ && !r_err) begin
                r_out_value <= rd_data;
            end else begin
                r_out_value <= '0;
            end
        end
    end

    // Status toward the controller
    always_comb begin
        o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
        o_sts.err       = r_err;
        o_sts.mode      = r_mode;
        o_sts.fill_last = col_last && (r_row == r_row_end);
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/rectangle_fill_engine.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine
// Fills rectangles of a row-major grid of signed 32-bit cells and reads
// single cells back, one result per item.
//
//   channel   direction  handshake         contents
//   i_cmd     in         valid/ready       mode, two corners, fill value
//   o_rsp     out        valid/ready       read value, status
//   APB       in/out     psel/penable      grid_rows, grid_cols, corner_order
//
// A fill writes the memory once per cell, one cell per cycle.
// A read steps through setup, the registered memory read and the post; a
// rejected item goes from setup straight to the post.
// After reset all MAX_ROWS*MAX_COLS cells (4096 by default) are swept to
// zero; no item is taken until the sweep ends.
// A result waits in the output register; the next item is accepted meanwhile
// and only its own result post stalls on a full output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_fill_engine #(
    parameter int MAX_ROWS = rfe_pkg::C_MAX_ROWS,
    parameter int MAX_COLS = rfe_pkg::C_MAX_COLS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rfe_cmd_if.sink                            i_cmd,
    rfe_rsp_if.source                          o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rfe_pkg::C_CFG_AW-1:0]  paddr,
    input  wire logic [rfe_pkg::C_CFG_DW-1:0]  pwdata,
    output logic      [rfe_pkg::C_CFG_DW-1:0]  prdata,
    output logic                               pready
);
    import rfe_pkg::*;

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rfe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    rfe_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_mode       (i_cmd.mode),
        .i_first_row  (i_cmd.first_row),
        .i_first_col  (i_cmd.first_col),
        .i_second_row (i_cmd.second_row),
        .i_second_col (i_cmd.second_col),
        .i_fill_value (i_cmd.fill_value),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_read_value (o_rsp.read_value),
        .o_status     (o_rsp.status)
    );

endmodule

`default_nettype wire

// ===== rtl/rfe_checker.sv =====
// ----------------------------------------------------------------------------
// Rectangle fill engine port checker
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rectangle_fill_engine_macros.svh"

module rfe_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic signed [rfe_pkg::C_DATA_W-1:0] i_read_value,
    input wire logic                                i_status
);
    import rfe_pkg::*;

    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic       in_xact;
    logic       out_xact;
    logic       out_stall;

    assign in_xact   = i_in_valid && i_in_ready;
    assign out_xact  = i_out_valid && i_out_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // Track items accepted but not yet answered
    always_comb begin
        n_pend = r_pend;
        if (in_xact && !out_xact) begin
            n_pend = r_pend + 1'b1;
        end else if (out_xact && !in_xact) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // Hold a stalled result
    `RFE_ASSERT_NXT(a_rsp_hold, out_stall, i_out_valid && $stable(i_read_value) && $stable(i_status))
    // Never a result without an outstanding item
    `RFE_ASSERT_NOW(a_rsp_owed, i_out_valid, r_pend != 2'd0)
    // Take a new item only with at most one result still waiting
    `RFE_ASSERT_NOW(a_one_ahead, i_in_ready, r_pend <= 2'd1)
    // Rejected items carry a zero value
    `RFE_ASSERT_NOW(a_reject_zero, i_out_valid && i_status == STATUS_REJECT, i_read_value == '0)

endmodule

bind rectangle_fill_engine rfe_checker u_rfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_read_value (o_rsp.read_value),
    .i_status     (o_rsp.status)
);

`default_nettype wire
